// File: src/plsu_pkg.sv
`timescale 1ns / 1ps

package plsu_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 6;
    localparam int POS_W  = 6;
    localparam int OP_W   = 2;

    // stream word widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] value_out;
        logic [LEN_W-1:0]  list_length;
    } result_t;

endpackage

// File: src/plsu_ram.sv
`timescale 1ns / 1ps

module plsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/plsu_ctrl.sv
`timescale 1ns / 1ps

module plsu_ctrl #(
    parameter int CAPACITY   = 32,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [plsu_pkg::OP_W-1:0]            in_opcode,
    input  logic [plsu_pkg::POS_W-1:0]           in_position,
    input  logic [plsu_pkg::DATA_W-1:0]          in_value,
    output logic                                 ram_we,
    output logic [$clog2(CAPACITY)-1:0]          ram_waddr,
    output logic [ELEM_WIDTH-1:0]                ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]          ram_raddr,
    input  logic [ELEM_WIDTH-1:0]                ram_rdata,
    output plsu_pkg::result_t                    res,
    output logic                                 res_valid,
    input  logic                                 res_ready
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((CNT_W > plsu_pkg::POS_W) ? CNT_W : plsu_pkg::POS_W) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SHRD   = 3'd2;
    localparam logic [2:0] S_SHWR   = 3'd3;
    localparam logic [2:0] S_INSWR  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [plsu_pkg::OP_W-1:0]        op_reg, op_next;
    logic [CW-1:0]                    pos_reg, pos_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [ELEM_WIDTH-1:0]            val_reg, val_next;
    logic                             status_reg, status_next;
    logic [plsu_pkg::DATA_W-1:0]      value_reg, value_next;

    logic [CW-1:0] pos_w, cnt_w, idx_inc, idx_dec;
    logic          pos_nz, rd_ok, ins_ok, is_ins;

    assign pos_w   = CW'(in_position);
    assign cnt_w   = CW'(count_reg);
    assign pos_nz  = (in_position != '0);
    assign rd_ok   = pos_nz && (pos_w <= cnt_w);
    assign ins_ok  = (cnt_w < CW'(CAPACITY)) && pos_nz && (pos_w <= cnt_w + CW'(1));
    assign is_ins  = (op_reg == plsu_pkg::OP_INSERT);

    // step units: neighbor indices for the shift loop
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);

    assign res.status      = status_reg;
    assign res.value_out   = value_reg;
    assign res.list_length = plsu_pkg::LEN_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        status_next = status_reg;
        value_next  = value_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(idx_reg);
        ram_wdata   = ram_rdata;
        ram_raddr   = AW'(idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = AW'(pos_w - CW'(1));
                if (in_valid)
                begin
                    op_next     = in_opcode;
                    pos_next    = pos_w;
                    val_next    = ELEM_WIDTH'($signed(in_value));
                    status_next = 1'b1;
                    value_next  = '0;
                    state_next  = S_FINISH;
                    case (in_opcode)
                        plsu_pkg::OP_READ:
                        begin
                            if (rd_ok)
                            begin
                                state_next = S_RDWAIT;
                            end
                        end
                        plsu_pkg::OP_DELETE:
                        begin
                            if (rd_ok)
                            begin
                                idx_next   = pos_w;
                                state_next = S_RDWAIT;
                            end
                        end
                        plsu_pkg::OP_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                idx_next   = cnt_w;
                                state_next = (cnt_w >= pos_w) ? S_SHRD : S_INSWR;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                status_next = 1'b0;
                value_next  = plsu_pkg::DATA_W'($signed(ram_rdata));
                if (op_reg == plsu_pkg::OP_DELETE)
                begin
                    if (idx_reg < cnt_w)
                    begin
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHRD:
            begin
                // insert moves entry idx-1 up, delete moves entry idx down
                ram_raddr  = is_ins ? AW'(idx_dec) : AW'(idx_reg);
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = is_ins ? AW'(idx_reg) : AW'(idx_dec);
                ram_wdata = ram_rdata;
                if (is_ins)
                begin
                    idx_next   = idx_dec;
                    state_next = (idx_dec >= pos_reg) ? S_SHRD : S_INSWR;
                end
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc < cnt_w)
                    begin
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_FINISH;
                    end
                end
            end
            S_INSWR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = AW'(pos_reg - CW'(1));
                ram_wdata   = val_reg;
                count_next  = count_reg + CNT_W'(1);
                status_next = 1'b0;
                value_next  = '0;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        value_reg  <= value_next;
    end

endmodule

// File: src/positional_list_store_unit.sv
`timescale 1ns / 1ps

// channel   dir  tdata                                  tuser
// s_axis    in   position[5:0] value_in[37:6] (40 b)    opcode[1:0]
// m_axis    out  value_out[31:0] list_length[37:32]     status[0]
//
// a delete shifts each later entry down, an insert shifts the entries from
// the position on up and then writes the value, a failed request skips the
// ram; the shift loop moves each entry by a registered ram read and the write
// rst_n clears the length and the sequencer; the ram holds no reset state
// the result sits in an output register, so a stalled m_axis still lets one
// more word in; its result then waits in the sequencer and blocks s_axis
module positional_list_store_unit #(
    parameter int CAPACITY   = 32,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [plsu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // position, value_in
    input  logic [plsu_pkg::OP_W-1:0]           s_axis_tuser,   // opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [plsu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // value_out, list_length
    output logic [0:0]                          m_axis_tuser    // status
);

    localparam int AW = $clog2(CAPACITY);

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

    plsu_pkg::result_t res, out_reg;
    logic              res_valid, res_ready;
    logic              out_valid_reg;

    plsu_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plsu_ctrl #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_opcode   (s_axis_tuser),
        .in_position (s_axis_tdata[plsu_pkg::POS_W-1:0]),
        .in_value    (s_axis_tdata[plsu_pkg::POS_W +: plsu_pkg::DATA_W]),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    // output slot frees when empty or when the word is taken this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{(plsu_pkg::OUT_TDATA_W - plsu_pkg::DATA_W - plsu_pkg::LEN_W){1'b0}},
                            out_reg.list_length, out_reg.value_out};

endmodule

// File: dv/tb_positional_list_store_unit.sv
`timescale 1ns / 1ps

module tb_positional_list_store_unit;

    localparam int CAP        = 32;
    localparam int EW         = 32;
    localparam int N_RANDOM   = 1550;
    localparam int CYCLE_CAP  = 800000;
    localparam int TAIL_WAIT  = 100;

    localparam logic [plsu_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [plsu_pkg::OP_W-1:0]   op;
        logic [plsu_pkg::POS_W-1:0]  pos;
        logic [plsu_pkg::DATA_W-1:0] val;
        bit                          drain;
    } list_cmd_t;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} gen_phase_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [plsu_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;     // position, value_in
    logic [plsu_pkg::OP_W-1:0]        s_axis_tuser = '0;     // opcode
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [plsu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;          // value_out, list_length
    logic [0:0]                       m_axis_tuser;          // status

    list_cmd_t          cmd_q[$];
    plsu_pkg::result_t  result_q[$];

    // predicted list contents
    logic [plsu_pkg::DATA_W-1:0] list_mem[CAP];
    int                          list_len = 0;

    // length as seen while building the stimulus
    int gen_len = 0;

    int words_offered = 0;
    int words_taken   = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int ready_run  = 0;
    int stall_run  = 0;

    always #4 clk = ~clk;

    positional_list_store_unit #(
        .CAPACITY   (CAP),
        .ELEM_WIDTH (EW)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic plsu_pkg::result_t apply_list_op(logic [plsu_pkg::OP_W-1:0] op,
                                                        logic [plsu_pkg::POS_W-1:0] pos,
                                                        logic [plsu_pkg::DATA_W-1:0] val);
        plsu_pkg::result_t r;
        int                p;
        int                k;
        p = pos;
        r.status    = 1'b1;
        r.value_out = '0;
        if (op == plsu_pkg::OP_READ)
        begin
            if (p >= 1 && p <= list_len)
            begin
                r.value_out = list_mem[p-1];
                r.status    = 1'b0;
            end
        end
        else if (op == plsu_pkg::OP_INSERT)
        begin
            if (list_len < CAP && p >= 1 && p <= list_len + 1)
            begin
                for (k = list_len; k >= p; k--)
                    list_mem[k] = list_mem[k-1];
                list_mem[p-1] = val;
                list_len++;
                r.status = 1'b0;
            end
        end
        else if (op == plsu_pkg::OP_DELETE)
        begin
            if (list_len > 0 && p >= 1 && p <= list_len)
            begin
                r.value_out = list_mem[p-1];
                for (k = p; k < list_len; k++)
                    list_mem[k-1] = list_mem[k];
                list_len--;
                r.status = 1'b0;
            end
        end
        r.list_length = list_len[plsu_pkg::LEN_W-1:0];
        return r;
    endfunction

    task automatic add_cmd(logic [plsu_pkg::OP_W-1:0] op, int pos,
                           logic [plsu_pkg::DATA_W-1:0] val, bit drain);
        list_cmd_t c;
        c.op    = op;
        c.pos   = pos[plsu_pkg::POS_W-1:0];
        c.val   = val;
        c.drain = drain;
        cmd_q.push_back(c);
        if (op == plsu_pkg::OP_INSERT && gen_len < CAP && pos >= 1 && pos <= gen_len + 1)
            gen_len++;
        else if (op == plsu_pkg::OP_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    // sender: bursts with gaps, optional hold until the result queue is empty
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && words_offered != words_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() == 0 || (cmd_q[0].drain && result_q.size() != 0))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cmd_q[0].op;
                s_axis_tdata  <= {2'b00, cmd_q[0].val, cmd_q[0].pos};
                void'(cmd_q.pop_front());
                words_offered <= words_offered + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: runs of ready broken by short or long stalls
    always @(negedge clk)
    begin
        int pick;
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
            m_axis_tready <= 1'b0;
        end
        else if (ready_run > 0)
        begin
            ready_run <= ready_run - 1;
            m_axis_tready <= 1'b1;
        end
        else
        begin
            pick = $urandom_range(0, 2);
            ready_run <= $urandom_range(1, 60);
            stall_run <= (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 3)
                                                       : $urandom_range(5, 25);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        plsu_pkg::result_t got;
        plsu_pkg::result_t want;
        got.status      = m_axis_tuser[0];
        got.value_out   = m_axis_tdata[31:0];
        got.list_length = m_axis_tdata[37:32];
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (result_q.size() == 0)
            begin
                $error("result word with nothing expected: status %0d value %0h length %0d",
                       got.status, got.value_out, got.list_length);
                err_cnt++;
            end
            else
            begin
                want = result_q.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    err_cnt++;
                end
                if (got.value_out !== want.value_out)
                begin
                    $error("value_out: expected %0h, got %0h", want.value_out, got.value_out);
                    err_cnt++;
                end
                if (got.list_length !== want.list_length)
                begin
                    $error("list_length: expected %0d, got %0d",
                           want.list_length, got.list_length);
                    err_cnt++;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            result_q.push_back(apply_list_op(s_axis_tuser, s_axis_tdata[5:0],
                                             s_axis_tdata[37:6]));
            words_taken <= words_taken + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP)
        begin
            $display("positional_list_store_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        gen_phase_t                  gen_phase;
        int                          phase_left;
        int                          n;
        int                          roll;
        int                          pos;
        logic [plsu_pkg::OP_W-1:0]   op;
        logic [plsu_pkg::DATA_W-1:0] val;

        // empty list, bad positions, extremes of the element value
        add_cmd(plsu_pkg::OP_READ,   1,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_DELETE, 1,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 0,  32'h1, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 2,  32'h2, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 1,  32'h7FFF_FFFF, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 1,  32'h8000_0000, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 3,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 2,  32'hFFFF_FFFF, 1'b0);
        add_cmd(plsu_pkg::OP_READ,   0,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_READ,   4,  32'hFFFF_FFFF, 1'b0);
        add_cmd(plsu_pkg::OP_READ,   5,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_READ,   63, 32'h0, 1'b0);
        add_cmd(OP_UNUSED,           1,  32'h1234_5678, 1'b0);
        add_cmd(plsu_pkg::OP_INSERT, 63, 32'h5555_AAAA, 1'b0);
        add_cmd(plsu_pkg::OP_DELETE, 0,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_DELETE, 5,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_DELETE, 4,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_DELETE, 1,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_READ,   1,  32'h0, 1'b0);
        add_cmd(plsu_pkg::OP_READ,   2,  32'h0, 1'b1);

        // first phase fills the list so inserts into a full list occur early
        gen_phase  = PH_GROW;
        phase_left = 90;
        for (n = 0; n < N_RANDOM; n++)
        begin
            if (phase_left == 0)
            begin
                gen_phase  = gen_phase_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 90);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            case (gen_phase)
                PH_GROW:   op = (roll < 70) ? plsu_pkg::OP_INSERT :
                                (roll < 90) ? plsu_pkg::OP_READ : plsu_pkg::OP_DELETE;
                PH_SHRINK: op = (roll < 70) ? plsu_pkg::OP_DELETE :
                                (roll < 90) ? plsu_pkg::OP_READ : plsu_pkg::OP_INSERT;
                PH_MIXED:  op = (roll < 34) ? plsu_pkg::OP_INSERT :
                                (roll < 67) ? plsu_pkg::OP_READ : plsu_pkg::OP_DELETE;
                default:   op = plsu_pkg::OP_W'($urandom_range(0, 3));
            endcase
            if (gen_phase == PH_NOISE || $urandom_range(0, 99) < 12)
                pos = $urandom_range(0, 63);
            else if (op == plsu_pkg::OP_INSERT)
                pos = $urandom_range(1, gen_len + 1);
            else
                pos = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
            case ($urandom_range(0, 9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0;
                default: val = $urandom;
            endcase
            add_cmd(op, pos, val, $urandom_range(0, 199) == 0);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_q.size() != 0 || words_offered != words_taken || result_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (err_cnt == 0 && result_q.size() == 0)
            $display("positional_list_store_unit verification clean");
        else
            $display("positional_list_store_unit verification failed");
        $finish;
    end

endmodule

// File: positional_list_store_unit.f
src/plsu_pkg.sv
src/plsu_ram.sv
src/plsu_ctrl.sv
src/positional_list_store_unit.sv
dv/tb_positional_list_store_unit.sv
